[hw/rtl/row_column_swap_table_defines.svh]
// assertion macros used by the table control rtl
`ifndef ROW_COLUMN_SWAP_TABLE_DEFINES_SVH
`define ROW_COLUMN_SWAP_TABLE_DEFINES_SVH

// same-cycle implication, off during reset
`define RCST_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define RCST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/rcst_pkg.sv]
package rcst_pkg;

  localparam int CFG_DATA_W = 9;
  localparam int CFG_INDEX_W = 1;

  localparam logic [CFG_INDEX_W-1:0] REG_ROWS_IN_USE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_COLS_IN_USE = 1'b1;

  localparam logic [CFG_DATA_W-1:0] ROWS_IN_USE_RESET = 9'd256;
  localparam logic [CFG_DATA_W-1:0] COLS_IN_USE_RESET = 9'd256;

  typedef enum logic [1:0] {
    FUNC_LOAD      = 2'd0,
    FUNC_SWAP_COLS = 2'd1,
    FUNC_SWAP_ROWS = 2'd2,
    FUNC_GET       = 2'd3
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [7:0]         index_a;
    logic [7:0]         index_b;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic               status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SWAP_RD_B,
    S_SWAP_WR_A,
    S_SWAP_WR_B,
    S_GET_CELL,
    S_GET_DATA,
    S_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic cell_write;
    logic cell_read;
    logic row_read;
    logic row_sel_b;
    logic col_read;
    logic col_sel_b;
    logic tmp_load;
    logic row_write;
    logic col_write;
    logic write_b;
    logic result_load;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    func_t func;
    logic  in_range;
    logic  out_valid;
  } dp_status_t;

endpackage

[hw/rtl/rcst_map_ram.sv]
module rcst_map_ram #(
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] valid;

  // entries never written read as their own index
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= valid[rd_addr] ? mem[rd_addr] : rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

endmodule

[hw/rtl/rcst_cell_ram.sv]
module rcst_cell_ram #(
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic               rd_en,
  input  logic [AW-1:0]      addr,
  input  logic signed [31:0] wr_data,
  output logic signed [31:0] rd_data
);

  logic signed [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

endmodule

[hw/rtl/rcst_datapath.sv]
module rcst_datapath #(
  parameter int ROWS = 256,
  parameter int COLS = 256
) (
  input  logic                                clk,
  input  logic                                rst,
  input  rcst_pkg::dp_cmd_t                   cmd,
  output rcst_pkg::dp_status_t                status,
  input  rcst_pkg::in_item_t                  in_data,
  input  logic                                cfg_write,
  input  logic [rcst_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [rcst_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                out_ready,
  output logic                                out_valid,
  output rcst_pkg::out_item_t                 out_data
);

  localparam int MAP_R = (ROWS < 256) ? ROWS : 256;
  localparam int MAP_C = (COLS < 256) ? COLS : 256;
  localparam int RAW = $clog2(MAP_R);
  localparam int CAW_MAP = $clog2(MAP_C);
  localparam int CELLS = ROWS * COLS;
  localparam int CAW = $clog2(CELLS);

  logic [rcst_pkg::CFG_DATA_W-1:0] rows_in_use;
  logic [rcst_pkg::CFG_DATA_W-1:0] cols_in_use;

  rcst_pkg::in_item_t item;
  logic               in_range;
  logic               in_range_next;
  logic signed [31:0] result;

  logic [RAW-1:0]     row_q;
  logic [RAW-1:0]     tmp_row;
  logic [RAW-1:0]     row_rd_addr;
  logic [RAW-1:0]     row_wr_addr;
  logic [RAW-1:0]     row_wr_data;
  logic [CAW_MAP-1:0] col_q;
  logic [CAW_MAP-1:0] tmp_col;
  logic [CAW_MAP-1:0] col_rd_addr;
  logic [CAW_MAP-1:0] col_wr_addr;
  logic [CAW_MAP-1:0] col_wr_data;
  logic [CAW-1:0]     cell_addr;
  logic signed [31:0] cell_q;

  logic a_row_ok;
  logic b_row_ok;
  logic a_col_ok;
  logic b_col_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= rcst_pkg::ROWS_IN_USE_RESET;
      cols_in_use <= rcst_pkg::COLS_IN_USE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rcst_pkg::REG_ROWS_IN_USE: rows_in_use <= cfg_data;
        rcst_pkg::REG_COLS_IN_USE: cols_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // bounds against both the register and the built size
  always_comb begin
    a_row_ok = ({1'b0, in_data.index_a} < rows_in_use) && (32'(in_data.index_a) < ROWS);
    b_row_ok = ({1'b0, in_data.index_b} < rows_in_use) && (32'(in_data.index_b) < ROWS);
    a_col_ok = ({1'b0, in_data.index_a} < cols_in_use) && (32'(in_data.index_a) < COLS);
    b_col_ok = ({1'b0, in_data.index_b} < cols_in_use) && (32'(in_data.index_b) < COLS);
    case (in_data.func)
      rcst_pkg::FUNC_SWAP_COLS: in_range_next = a_col_ok && b_col_ok;
      rcst_pkg::FUNC_SWAP_ROWS: in_range_next = a_row_ok && b_row_ok;
      default:                  in_range_next = a_row_ok && b_col_ok;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item     <= in_data;
      in_range <= in_range_next;
      result   <= '0;
    end else if (cmd.result_load) begin
      result <= cell_q;
    end
    if (cmd.tmp_load) begin
      tmp_row <= row_q;
      tmp_col <= col_q;
    end
  end

  assign row_rd_addr = cmd.row_sel_b ? item.index_b[RAW-1:0] : item.index_a[RAW-1:0];
  assign col_rd_addr = cmd.col_sel_b ? item.index_b[CAW_MAP-1:0] : item.index_a[CAW_MAP-1:0];
  assign row_wr_addr = cmd.write_b ? item.index_b[RAW-1:0] : item.index_a[RAW-1:0];
  assign col_wr_addr = cmd.write_b ? item.index_b[CAW_MAP-1:0] : item.index_a[CAW_MAP-1:0];
  assign row_wr_data = cmd.write_b ? tmp_row : row_q;
  assign col_wr_data = cmd.write_b ? tmp_col : col_q;

  rcst_map_ram #(.DEPTH(MAP_R)) u_row_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd.row_read),
    .rd_addr (row_rd_addr),
    .rd_data (row_q),
    .wr_en   (cmd.row_write),
    .wr_addr (row_wr_addr),
    .wr_data (row_wr_data)
  );

  rcst_map_ram #(.DEPTH(MAP_C)) u_col_map (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (cmd.col_read),
    .rd_addr (col_rd_addr),
    .rd_data (col_q),
    .wr_en   (cmd.col_write),
    .wr_addr (col_wr_addr),
    .wr_data (col_wr_data)
  );

  // mapped address for a get, physical address for a load
  always_comb begin
    if (cmd.cell_read) begin
      cell_addr = CAW'(row_q) * CAW'(COLS) + CAW'(col_q);
    end else begin
      cell_addr = CAW'(item.index_a) * CAW'(COLS) + CAW'(item.index_b);
    end
  end

  rcst_cell_ram #(.DEPTH(CELLS)) u_cells (
    .clk     (clk),
    .wr_en   (cmd.cell_write),
    .rd_en   (cmd.cell_read),
    .addr    (cell_addr),
    .wr_data (item.value),
    .rd_data (cell_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.read_value <= result;
      out_data.status     <= ~in_range;
    end
  end

  assign status.func      = item.func;
  assign status.in_range  = in_range;
  assign status.out_valid = out_valid;

endmodule

[hw/rtl/rcst_ctrl.sv]
`include "row_column_swap_table_defines.svh"

module rcst_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  input  rcst_pkg::dp_status_t status,
  output rcst_pkg::dp_cmd_t    cmd
);

  rcst_pkg::state_t state;
  rcst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rcst_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      rcst_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = rcst_pkg::S_EXEC;
        end
      end
      rcst_pkg::S_EXEC: begin
        if (!status.in_range) begin
          state_next = rcst_pkg::S_DONE;
        end else begin
          case (status.func)
            rcst_pkg::FUNC_LOAD: begin
              cmd.cell_write = 1'b1;
              state_next     = rcst_pkg::S_DONE;
            end
            rcst_pkg::FUNC_SWAP_COLS: begin
              cmd.col_read = 1'b1;
              state_next   = rcst_pkg::S_SWAP_RD_B;
            end
            rcst_pkg::FUNC_SWAP_ROWS: begin
              cmd.row_read = 1'b1;
              state_next   = rcst_pkg::S_SWAP_RD_B;
            end
            default: begin
              cmd.row_read  = 1'b1;
              cmd.col_read  = 1'b1;
              cmd.col_sel_b = 1'b1;
              state_next    = rcst_pkg::S_GET_CELL;
            end
          endcase
        end
      end
      rcst_pkg::S_SWAP_RD_B: begin
        cmd.tmp_load = 1'b1;
        if (status.func == rcst_pkg::FUNC_SWAP_ROWS) begin
          cmd.row_read  = 1'b1;
          cmd.row_sel_b = 1'b1;
        end else begin
          cmd.col_read  = 1'b1;
          cmd.col_sel_b = 1'b1;
        end
        state_next = rcst_pkg::S_SWAP_WR_A;
      end
      rcst_pkg::S_SWAP_WR_A: begin
        cmd.row_write = (status.func == rcst_pkg::FUNC_SWAP_ROWS);
        cmd.col_write = (status.func != rcst_pkg::FUNC_SWAP_ROWS);
        state_next    = rcst_pkg::S_SWAP_WR_B;
      end
      rcst_pkg::S_SWAP_WR_B: begin
        cmd.row_write = (status.func == rcst_pkg::FUNC_SWAP_ROWS);
        cmd.col_write = (status.func != rcst_pkg::FUNC_SWAP_ROWS);
        cmd.write_b   = 1'b1;
        state_next    = rcst_pkg::S_DONE;
      end
      rcst_pkg::S_GET_CELL: begin
        cmd.cell_read = 1'b1;
        state_next    = rcst_pkg::S_GET_DATA;
      end
      rcst_pkg::S_GET_DATA: begin
        cmd.result_load = 1'b1;
        state_next      = rcst_pkg::S_DONE;
      end
      rcst_pkg::S_DONE: begin
        if (!status.out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = rcst_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = rcst_pkg::S_IDLE;
      end
    endcase
  end

  `RCST_ASSERT_NOW(a_out_load_free, cmd.out_load, !status.out_valid || out_ready,
                   "result loaded over an untaken result")
  `RCST_ASSERT_NOW(a_cell_write_load, cmd.cell_write,
                   status.in_range && status.func == rcst_pkg::FUNC_LOAD,
                   "cell write outside an in-range load")
  `RCST_ASSERT_NOW(a_one_map_write, 1'b1, !(cmd.row_write && cmd.col_write),
                   "both maps written in one cycle")
  `RCST_ASSERT_NEXT(a_swap_pair, state == rcst_pkg::S_SWAP_WR_A,
                    state == rcst_pkg::S_SWAP_WR_B, "swap lost its second write")

endmodule

[hw/rtl/row_column_swap_table.sv]
// row/column swap table: a word table read through a row map and a column map
// input channel in_valid/in_ready carries one item (func, index_a, index_b, value);
// output channel out_valid/out_ready returns one result (read_value, status) per item
// cfg_write/cfg_index/cfg_data write rows_in_use (index 0) or cols_in_use (index 1);
// the user must write them only while no item is in flight, the block does not enforce it
// items are handled one at a time by a state machine over synchronous memories;
// a load writes the table, a get does a map read then a table read, a swap does
// two map reads then two map writes, and an out-of-range item does none of these
// a new item is taken once the previous one sits in the output register, so the
// block does not take a new item before it is through with the last one
// a stalled receiver holds the result in the output register; the next item may be
// taken meanwhile and waits in its final state until the register frees
// reset (synchronous, active high) restores both maps to identity through per-entry
// valid bits at once and sets both bound registers to 256; the table itself is not
// cleared and a cell read before it is loaded returns an arbitrary word
module row_column_swap_table #(
  parameter int ROWS = 256,
  parameter int COLS = 256
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  rcst_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output rcst_pkg::out_item_t              out_data,
  input  logic                             cfg_write,
  input  logic [rcst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [rcst_pkg::CFG_DATA_W-1:0]  cfg_data
);

  rcst_pkg::dp_cmd_t    cmd;
  rcst_pkg::dp_status_t status;

  rcst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  rcst_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import rcst_pkg::*;

  localparam int TBL_ROWS = 256;
  localparam int TBL_COLS = 256;
  localparam int STALL_LIMIT = 5000;

  class table_scoreboard;
    logic [31:0] cells [int];
    logic [7:0] row_map [TBL_ROWS];
    logic [7:0] col_map [TBL_COLS];
    int unsigned row_bound;
    int unsigned col_bound;
    out_item_t expected_q [$];
    int errors;
    int n_load;
    int n_row_swap;
    int n_col_swap;
    int n_get;
    int n_reject;

    function new();
      for (int i = 0; i < TBL_ROWS; i++) row_map[i] = 8'(i);
      for (int i = 0; i < TBL_COLS; i++) col_map[i] = 8'(i);
      row_bound = TBL_ROWS;
      col_bound = TBL_COLS;
    endfunction

    function void set_bound(logic [CFG_INDEX_W-1:0] idx, int unsigned val);
      if (idx == REG_ROWS_IN_USE) begin
        row_bound = (val > TBL_ROWS) ? TBL_ROWS : val;
      end else begin
        col_bound = (val > TBL_COLS) ? TBL_COLS : val;
      end
    endfunction

    function int cell_key(int a, int b);
      return int'(row_map[a]) * TBL_COLS + int'(col_map[b]);
    endfunction

    // a get may only touch a cell that was loaded
    function bit get_safe(int a, int b);
      if (a >= row_bound || b >= col_bound) return 1'b1;
      return cells.exists(cell_key(a, b));
    endfunction

    function void note_input(in_item_t it);
      out_item_t e;
      int a;
      int b;
      logic [7:0] t;
      e = '0;
      a = int'(it.index_a);
      b = int'(it.index_b);
      case (it.func)
        FUNC_LOAD: begin
          n_load++;
          if (a < row_bound && b < col_bound) cells[a * TBL_COLS + b] = it.value;
          else e.status = 1'b1;
        end
        FUNC_SWAP_COLS: begin
          n_col_swap++;
          if (a < col_bound && b < col_bound) begin
            t = col_map[a];
            col_map[a] = col_map[b];
            col_map[b] = t;
          end else begin
            e.status = 1'b1;
          end
        end
        FUNC_SWAP_ROWS: begin
          n_row_swap++;
          if (a < row_bound && b < row_bound) begin
            t = row_map[a];
            row_map[a] = row_map[b];
            row_map[b] = t;
          end else begin
            e.status = 1'b1;
          end
        end
        default: begin
          n_get++;
          if (a < row_bound && b < col_bound) e.read_value = cells[cell_key(a, b)];
          else e.status = 1'b1;
        end
      endcase
      if (e.status) n_reject++;
      expected_q = {expected_q, e};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got read_value %h status %b",
                 $time, got.read_value, got.status);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (got.read_value !== e.read_value) begin
        $display("%0t: read_value mismatch, expected %h got %h",
                 $time, e.read_value, got.read_value);
        errors++;
      end
      if (got.status !== e.status) begin
        $display("%0t: status mismatch, expected %b got %b", $time, e.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit calm = 1'b0;
  int idle_cycles = 0;
  int items_sent = 0;
  int bound_settings = 0;
  table_scoreboard board = new();

  row_column_swap_table dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 30);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) board.check_result(out_data);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic in_item_t make_item(func_t f, int a, int b, int v);
    in_item_t it;
    it.func = f;
    it.index_a = 8'(a);
    it.index_b = 8'(b);
    it.value = v;
    return it;
  endfunction

  // mostly a small corner of the table, sometimes the whole bound or any index
  function automatic int pick_index(int unsigned bound);
    int r;
    int span;
    r = $urandom_range(0, 99);
    span = (bound > 16) ? 16 : ((bound == 0) ? 1 : bound);
    if (r < 8) return $urandom_range(0, 255);
    if (r < 16 && bound > 0) return $urandom_range(0, bound - 1);
    return $urandom_range(0, span - 1);
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int kind;
    int tries;
    it.value = $urandom();
    kind = $urandom_range(0, 99);
    if (kind < 15) begin
      it.func = func_t'($urandom_range(0, 3));
      it.index_a = 8'($urandom_range(0, 255));
      it.index_b = 8'($urandom_range(0, 255));
    end else if (kind < 40) begin
      it.func = FUNC_LOAD;
      it.index_a = 8'(pick_index(board.row_bound));
      it.index_b = 8'(pick_index(board.col_bound));
    end else if (kind < 55) begin
      it.func = FUNC_SWAP_ROWS;
      it.index_a = 8'(pick_index(board.row_bound));
      it.index_b = 8'(pick_index(board.row_bound));
    end else if (kind < 70) begin
      it.func = FUNC_SWAP_COLS;
      it.index_a = 8'(pick_index(board.col_bound));
      it.index_b = 8'(pick_index(board.col_bound));
    end else begin
      it.func = FUNC_GET;
      it.index_a = 8'(pick_index(board.row_bound));
      it.index_b = 8'(pick_index(board.col_bound));
    end
    if (it.func == FUNC_GET) begin
      tries = 0;
      while (tries < 4 && !board.get_safe(int'(it.index_a), int'(it.index_b))) begin
        it.index_a = 8'(pick_index(board.row_bound));
        it.index_b = 8'(pick_index(board.col_bound));
        tries++;
      end
      if (!board.get_safe(int'(it.index_a), int'(it.index_b))) it.func = FUNC_LOAD;
    end
    return it;
  endfunction

  // valid is left high so back-to-back transfers need no second assignment
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    board.note_input(it);
    items_sent++;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic set_bounds(input int rows, input int cols);
    drain();
    cfg_write <= 1'b1;
    cfg_index <= REG_ROWS_IN_USE;
    cfg_data <= 9'(rows);
    @(negedge clk);
    cfg_index <= REG_COLS_IN_USE;
    cfg_data <= 9'(cols);
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_bound(REG_ROWS_IN_USE, rows);
    board.set_bound(REG_COLS_IN_USE, cols);
    bound_settings++;
    @(negedge clk);
  endtask

  initial begin
    int phase_rows [9];
    int phase_cols [9];
    int phase_len [9];
    phase_rows = '{256, 16, 256, 1, 8, 300, 0, 2, 256};
    phase_cols = '{256, 16, 1, 256, 200, 511, 5, 2, 256};
    phase_len = '{100, 100, 80, 80, 100, 90, 20, 80, 100};

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // corners of the table with identity maps, then swapped maps
    send_item(make_item(FUNC_LOAD, 0, 0, 32'h8000_0000));
    send_item(make_item(FUNC_LOAD, 255, 255, 32'h7fff_ffff));
    send_item(make_item(FUNC_LOAD, 0, 255, 32'hffff_ffff));
    send_item(make_item(FUNC_LOAD, 255, 0, 0));
    send_item(make_item(FUNC_GET, 0, 0, 0));
    send_item(make_item(FUNC_GET, 255, 255, 0));
    send_item(make_item(FUNC_SWAP_ROWS, 0, 255, 0));
    send_item(make_item(FUNC_SWAP_COLS, 0, 255, 0));
    send_item(make_item(FUNC_GET, 0, 0, 0));
    send_item(make_item(FUNC_GET, 255, 0, 0));
    send_item(make_item(FUNC_SWAP_ROWS, 3, 3, 0));
    send_item(make_item(FUNC_SWAP_COLS, 7, 7, 0));
    send_item(make_item(FUNC_GET, 0, 255, 0));

    // zero rows: every row index rejected
    set_bounds(0, 256);
    send_item(make_item(FUNC_LOAD, 0, 0, 32'h1234_5678));
    send_item(make_item(FUNC_GET, 0, 0, 0));
    send_item(make_item(FUNC_SWAP_ROWS, 0, 1, 0));
    send_item(make_item(FUNC_SWAP_COLS, 1, 2, 0));

    // oversized row register is capped by the built size, single column
    set_bounds(511, 1);
    send_item(make_item(FUNC_LOAD, 255, 0, 32'h0bad_cafe));
    send_item(make_item(FUNC_LOAD, 0, 1, 32'h5555_aaaa));
    send_item(make_item(FUNC_SWAP_COLS, 0, 0, 0));
    send_item(make_item(FUNC_SWAP_COLS, 0, 1, 0));
    send_item(make_item(FUNC_GET, 255, 0, 0));

    // shrunk bounds: map points past the bound, cell still read
    set_bounds(1, 1);
    send_item(make_item(FUNC_GET, 0, 0, 0));
    send_item(make_item(FUNC_SWAP_ROWS, 0, 0, 0));

    for (int p = 0; p < 9; p++) begin
      set_bounds(phase_rows[p], phase_cols[p]);
      calm = (p == 1);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 4 && n == 40) drain();
        send_item(random_item());
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (board.expected_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("sent %0d items: %0d loads, %0d row swaps, %0d column swaps, %0d gets",
             items_sent, board.n_load, board.n_row_swap, board.n_col_swap, board.n_get);
    $display("%0d items rejected as out of range across %0d bound settings",
             board.n_reject, bound_settings);
    if (board.errors == 0 && board.expected_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
